// ===== rtl/linear_probe_hash_multimap_assert.svh =====
// Assertion macros for the hash multimap RTL
`ifndef LINEAR_PROBE_HASH_MULTIMAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MULTIMAP_ASSERT_SVH

// same-cycle implication
`define LPHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lphm_pkg.sv =====
// Package: types, codes and hash function of the hash multimap
package lphm_pkg;

    localparam int TABLE_DEPTH_DEF     = 1024;
    localparam int VALUES_PER_SLOT_DEF = 8;
    localparam int HANDLE_BITS_DEF     = 16;
    localparam int CFG_W               = 11;
    localparam int KEY_W               = 64;
    localparam int IN_HANDLE_W         = 16;
    localparam int STATUS_W            = 3;
    localparam int SLOT_OUT_W          = 10;
    localparam int CNT_OUT_W           = 4;
    localparam int VAL_OUT_W           = 16;
    localparam int ENTRY_OUT_W         = 11;
    localparam int ROT                 = 3;
    localparam int KEY_BYTES           = 8;
    localparam int IN_DATA_W           = 80;
    localparam int OUT_DATA_W          = 48;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW_SLOT  = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_TBL_FULL  = 3'd2,
        ST_LIST_FULL = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_CLR_DONE, S_HASH, S_RD, S_CHK, S_LK_RD, S_LK_EMIT
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    clr_step;
        logic    hash_step;
        logic    rd_issue;
        logic    probe_next;
        logic    ins_new;
        logic    ins_app;
        logic    lk_start;
        logic    lk_rd;
        logic    lk_next;
        logic    emit;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic sweep_last;
        logic hash_last;
        logic cnt_zero;
        logic key_match;
        logic cnt_full;
        logic probe_last;
        logic lk_last;
        logic out_free;
    } t_sts;

    function automatic logic [KEY_W-1:0] hash_key(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            h = h ^ {56'd0, key[8*i +: 8]};
            h = {h[KEY_W-1-ROT:0], h[KEY_W-1 -: ROT]};
        end
        return h;
    endfunction

endpackage

// ===== rtl/lphm_ctrl.sv =====
// Controller state machine of the hash multimap
module lphm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lphm_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lphm_pkg::t_cmd o_cmd
);
    import lphm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (i_sts.sweep_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_sts.op)
                        OP_INSERT, OP_LOOKUP: n_state = S_HASH;
                        OP_CLEAR:             n_state = S_CLR;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:      if (i_sts.sweep_last) n_state = S_CLR_DONE;
            S_CLR_DONE: if (i_sts.out_free) n_state = S_IDLE;
            S_HASH:     if (i_sts.hash_last) n_state = S_RD;
            S_RD:       n_state = S_CHK;
            S_CHK: begin
                if (i_sts.key_match && !i_sts.cnt_zero && i_sts.op == OP_LOOKUP) begin
                    n_state = S_LK_RD;
                end else if (i_sts.cnt_zero || i_sts.key_match || i_sts.probe_last) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_LK_RD:    n_state = S_LK_EMIT;
            S_LK_EMIT:  if (i_sts.out_free) n_state = i_sts.lk_last ? S_IDLE : S_LK_RD;
            default:    n_state = S_INIT;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            S_CLR:   o_cmd.clr_step = 1'b1;
            S_CLR_DONE: begin
                o_cmd.emit        = i_sts.out_free;
                o_cmd.emit_status = ST_CLEARED;
            end
            S_HASH:  o_cmd.hash_step = 1'b1;
            S_RD:    o_cmd.rd_issue = 1'b1;
            S_CHK: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.emit = i_sts.out_free;
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.emit_status = ST_NEW_SLOT;
                        o_cmd.ins_new     = i_sts.out_free;
                    end else begin
                        o_cmd.emit_status = ST_NOT_FOUND;
                    end
                end else if (i_sts.key_match) begin
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.emit = i_sts.out_free;
                        if (i_sts.cnt_full) begin
                            o_cmd.emit_status = ST_LIST_FULL;
                        end else begin
                            o_cmd.emit_status = ST_APPENDED;
                            o_cmd.ins_app     = i_sts.out_free;
                        end
                    end else begin
                        o_cmd.lk_start = 1'b1;
                    end
                end else if (i_sts.probe_last) begin
                    o_cmd.emit        = i_sts.out_free;
                    o_cmd.emit_status = (i_sts.op == OP_INSERT) ? ST_TBL_FULL : ST_NOT_FOUND;
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_LK_RD: o_cmd.lk_rd = 1'b1;
            S_LK_EMIT: begin
                o_cmd.emit        = i_sts.out_free;
                o_cmd.lk_next     = i_sts.out_free;
                o_cmd.emit_status = ST_FOUND;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lphm_dp.sv =====
// Datapath of the hash multimap: memories, hash remainder, probe and output register
module lphm_dp #(
    parameter int TABLE_DEPTH     = lphm_pkg::TABLE_DEPTH_DEF,
    parameter int VALUES_PER_SLOT = lphm_pkg::VALUES_PER_SLOT_DEF,
    parameter int HANDLE_BITS     = lphm_pkg::HANDLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lphm_pkg::t_cmd                      i_cmd,
    output lphm_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [lphm_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [1:0]                          i_op,
    input  logic [lphm_pkg::KEY_W-1:0]          i_key,
    input  logic [lphm_pkg::IN_HANDLE_W-1:0]    i_handle,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [lphm_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast
);
    import lphm_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int SZ_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (SZ_W > CFG_W) ? SZ_W : CFG_W;
    localparam int CNT_W  = $clog2(VALUES_PER_SLOT + 1);
    localparam int VA_W   = $clog2(TABLE_DEPTH * VALUES_PER_SLOT);
    localparam int BIT_W  = $clog2(KEY_W);

    logic [CFG_W-1:0]       r_cfg;
    logic [SZ_W-1:0]        r_size;
    t_op                    r_op;
    logic [KEY_W-1:0]       r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_W-1:0]       r_hash;
    logic [BIT_W-1:0]       r_bit;
    logic [SZ_W-1:0]        r_rem;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_n;
    logic [SLOT_W-1:0]      r_sweep;
    logic [SZ_W-1:0]        r_occ;
    logic [CNT_W-1:0]       r_k;
    logic [KEY_W-1:0]       r_rd_key;
    logic [CNT_W-1:0]       r_rd_cnt;
    logic [HANDLE_BITS-1:0] r_rd_val;

    logic [KEY_W-1:0]       mem_key [TABLE_DEPTH];
    logic [CNT_W-1:0]       mem_cnt [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] mem_val [TABLE_DEPTH * VALUES_PER_SLOT];

    logic                   r_ovalid;
    logic                   r_olast;
    t_status                r_ostatus;
    logic [SLOT_OUT_W-1:0]  r_oslot;
    logic [CNT_OUT_W-1:0]   r_ocnt;
    logic [VAL_OUT_W-1:0]   r_oval;
    logic [ENTRY_OUT_W-1:0] r_oentry;

    logic [CMP_W-1:0]  cfg_ext;
    logic [SZ_W-1:0]   size_act;
    logic [SZ_W:0]     rem_sh;
    logic [SZ_W-1:0]   rem_nx;
    logic [VA_W-1:0]   va_base;
    logic [CNT_W-1:0]  cnt_inc;
    logic              out_free;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wd;
    logic [SLOT_W-1:0] cnt_wa;

    always_comb begin
        cfg_ext = CMP_W'(r_cfg);
        if (cfg_ext == '0)                       size_act = SZ_W'(1);
        else if (cfg_ext > CMP_W'(TABLE_DEPTH))  size_act = SZ_W'(TABLE_DEPTH);
        else                                     size_act = SZ_W'(cfg_ext);
    end

    assign rem_sh  = {r_rem, r_hash[KEY_W-1]};
    assign rem_nx  = (rem_sh >= {1'b0, r_size}) ? SZ_W'(rem_sh - {1'b0, r_size})
                                                : SZ_W'(rem_sh);
    assign va_base = VA_W'(r_idx) * VA_W'(VALUES_PER_SLOT);
    assign cnt_inc = r_rd_cnt + CNT_W'(1);
    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= CFG_W'(TABLE_DEPTH_DEF);
        else if (i_cfg_we) r_cfg <= i_cfg_wdata;
    end

    // item registers, hash remainder and probe walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= t_op'(i_op);
            r_key    <= i_key;
            r_handle <= HANDLE_BITS'(i_handle);
            r_hash   <= hash_key(i_key);
            r_size   <= size_act;
            r_rem    <= '0;
            r_bit    <= '0;
        end
        if (i_cmd.hash_step) begin
            r_hash <= {r_hash[KEY_W-2:0], 1'b0};
            r_rem  <= rem_nx;
            r_bit  <= r_bit + BIT_W'(1);
            if (r_bit == BIT_W'(KEY_W - 1)) begin
                r_idx <= SLOT_W'(rem_nx);
                r_n   <= '0;
            end
        end
        if (i_cmd.probe_next) begin
            r_idx <= (SZ_W'(r_idx) == r_size - SZ_W'(1)) ? '0 : r_idx + SLOT_W'(1);
            r_n   <= r_n + SLOT_W'(1);
        end
        if (i_cmd.lk_start) r_k <= '0;
        if (i_cmd.lk_next)  r_k <= r_k + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_occ   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_sweep <= (r_sweep == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : r_sweep + SLOT_W'(1);
                if (r_sweep == SLOT_W'(TABLE_DEPTH - 1)) r_occ <= '0;
            end
            if (i_cmd.ins_new) r_occ <= r_occ + SZ_W'(1);
        end
    end

    // memories
    always_comb begin
        cnt_we = i_cmd.clr_step || i_cmd.ins_new || i_cmd.ins_app;
        cnt_wa = i_cmd.clr_step ? r_sweep : r_idx;
        cnt_wd = i_cmd.clr_step ? '0 : (i_cmd.ins_new ? CNT_W'(1) : cnt_inc);
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) mem_cnt[cnt_wa] <= cnt_wd;
        if (i_cmd.rd_issue) r_rd_cnt <= mem_cnt[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_new) mem_key[r_idx] <= r_key;
        if (i_cmd.rd_issue) r_rd_key <= mem_key[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_new)      mem_val[va_base] <= r_handle;
        else if (i_cmd.ins_app) mem_val[va_base + VA_W'(r_rd_cnt)] <= r_handle;
        if (i_cmd.lk_rd) r_rd_val <= mem_val[va_base + VA_W'(r_k)];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ostatus <= i_cmd.emit_status;
            r_olast   <= 1'b1;
            r_oval    <= '0;
            r_oentry  <= ENTRY_OUT_W'(r_occ);
            r_oslot   <= SLOT_OUT_W'(r_idx);
            r_ocnt    <= CNT_OUT_W'(r_rd_cnt);
            case (i_cmd.emit_status)
                ST_NEW_SLOT: begin
                    r_ocnt   <= CNT_OUT_W'(1);
                    r_oentry <= ENTRY_OUT_W'(r_occ + SZ_W'(1));
                end
                ST_APPENDED: r_ocnt <= CNT_OUT_W'(cnt_inc);
                ST_FOUND: begin
                    r_oval  <= VAL_OUT_W'(r_rd_val);
                    r_olast <= (r_k + CNT_W'(1)) == r_rd_cnt;
                end
                ST_LIST_FULL: r_ocnt <= CNT_OUT_W'(r_rd_cnt);
                default: begin
                    r_oslot <= '0;
                    r_ocnt  <= '0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {4'd0, r_oentry, r_oval, r_ocnt, r_oslot, r_ostatus};

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.sweep_last = (r_sweep == SLOT_W'(TABLE_DEPTH - 1));
        o_sts.hash_last  = (r_bit == BIT_W'(KEY_W - 1));
        o_sts.cnt_zero   = (r_rd_cnt == '0);
        o_sts.key_match  = (r_rd_key == r_key);
        o_sts.cnt_full   = (r_rd_cnt >= CNT_W'(VALUES_PER_SLOT));
        o_sts.probe_last = (SZ_W'(r_n) == r_size - SZ_W'(1));
        o_sts.lk_last    = ((r_k + CNT_W'(1)) == r_rd_cnt);
        o_sts.out_free   = out_free;
    end

`include "linear_probe_hash_multimap_assert.svh"

    `LPHM_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, i_cmd.emit, out_free, "result loaded over a pending one")
    `LPHM_ASSERT_NOW(a_occ_range, i_clk, i_rst_n, 1'b1, r_occ <= SZ_W'(TABLE_DEPTH), "occupancy beyond depth")
    `LPHM_ASSERT_NEXT(a_occ_inc, i_clk, i_rst_n, i_cmd.ins_new, r_occ == $past(r_occ) + SZ_W'(1), "occupancy not incremented")
    `LPHM_ASSERT_NOW(a_probe_range, i_clk, i_rst_n, i_cmd.rd_issue, SZ_W'(r_idx) < r_size, "probe outside active table")

endmodule

// ===== rtl/linear_probe_hash_multimap.sv =====
// Top level of the linear probing hash multimap
//
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   tdata: key, alg_handle; tuser: operation
//  m        out  o_m_tvalid/i_m_tready   tdata: status..entry_count; tlast: last
//  cfg      in   i_cfg_we                i_cfg_wdata: table_size
//
// Insert/lookup: accept, then the remainder (one hash bit per cycle through the
// modulo unit), then a read and a check per probed slot; lookup adds a read and an emit per handle.
// Clear: a sweep that zeroes the count memory slot by slot, then the result.
// After reset the same sweep runs before the first transfer.
// A stalled output holds the result register; the next item is taken meanwhile.
module linear_probe_hash_multimap #(
    parameter int TABLE_DEPTH     = lphm_pkg::TABLE_DEPTH_DEF,
    parameter int VALUES_PER_SLOT = lphm_pkg::VALUES_PER_SLOT_DEF,
    parameter int HANDLE_BITS     = lphm_pkg::HANDLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lphm_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // key [63:0], alg_handle [79:64]
    input  logic [lphm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // operation [1:0]
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status [2:0], slot [12:3], value_count [16:13], value_out [32:17],
    // entry_count [43:33], zero [47:44]
    output logic [lphm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import lphm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_sts sts_ctrl;

    // op is taken straight from the port while idle
    always_comb begin
        sts_ctrl    = sts;
        if (o_s_tready) sts_ctrl.op = t_op'(i_s_tuser);
    end

    lphm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_sts      (sts_ctrl),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    lphm_dp #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .VALUES_PER_SLOT (VALUES_PER_SLOT),
        .HANDLE_BITS     (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_tuser),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .i_handle    (i_s_tdata[KEY_W +: IN_HANDLE_W]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== bench/linear_probe_hash_multimap_tb.sv =====
// Testbench for linear_probe_hash_multimap: directed rows, then random phases checked by a predictor
`timescale 1ns / 1ps

module linear_probe_hash_multimap_tb;
    import lphm_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int PER_SLOT   = 8;
    localparam int TAIL_WAIT  = 2400;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        t_status     status;
        logic [9:0]  slot;
        logic [3:0]  cnt;
        logic [15:0] value;
        logic        last;
        logic [10:0] entries;
    } t_result;

    typedef struct {
        t_op         op;
        logic [63:0] key;
        logic [15:0] handle;
        logic        typed;
        t_status     exp_status;
        logic [10:0] exp_entries;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [1:0]             i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tlast;

    linear_probe_hash_multimap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow table
    logic [63:0] shadow_keys [DEPTH];
    int          shadow_counts [DEPTH];
    logic [15:0] shadow_values [DEPTH*PER_SLOT];
    int          shadow_entries;
    int          shadow_size;

    t_result pending_results [$];
    int      errors = 0;
    int      rx_count = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic int home_of(logic [63:0] key, int size);
        logic [63:0] h;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            h = h ^ {56'd0, key[8*i +: 8]};
            h = {h[60:0], h[63:61]};
        end
        return int'(h % 64'(size));
    endfunction

    task automatic push_result(t_status st, int slot, int cnt, logic [15:0] v, logic l);
        t_result r;
        r.status  = st;
        r.slot    = slot[9:0];
        r.cnt     = cnt[3:0];
        r.value   = v;
        r.last    = l;
        r.entries = shadow_entries[10:0];
        pending_results.push_back(r);
    endtask

    // returns number of results queued
    task automatic predict_op(t_op op, logic [63:0] key, logic [15:0] handle, output int n_out);
        int size, idx, c;
        bit done;
        size = (shadow_size == 0) ? 1 : (shadow_size > DEPTH ? DEPTH : shadow_size);
        n_out = 1;
        done = 0;
        if (op == OP_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) shadow_counts[i] = 0;
            shadow_entries = 0;
            push_result(ST_CLEARED, 0, 0, '0, 1'b1);
            return;
        end
        if (op == OP_NONE) begin
            n_out = 0;
            return;
        end
        idx = home_of(key, size);
        for (int n = 0; n < size && !done; n++) begin
            c = shadow_counts[idx];
            if (c == 0) begin
                if (op == OP_INSERT) begin
                    shadow_keys[idx] = key;
                    shadow_values[idx*PER_SLOT] = handle;
                    shadow_counts[idx] = 1;
                    shadow_entries++;
                    push_result(ST_NEW_SLOT, idx, 1, '0, 1'b1);
                    return;
                end
                done = 1;
            end else if (shadow_keys[idx] == key) begin
                if (op == OP_INSERT) begin
                    if (c >= PER_SLOT) begin
                        push_result(ST_LIST_FULL, idx, c, '0, 1'b1);
                    end else begin
                        shadow_values[idx*PER_SLOT + c] = handle;
                        shadow_counts[idx] = c + 1;
                        push_result(ST_APPENDED, idx, c + 1, '0, 1'b1);
                    end
                end else begin
                    for (int k = 0; k < c; k++)
                        push_result(ST_FOUND, idx, c, shadow_values[idx*PER_SLOT + k],
                                    k + 1 == c);
                    n_out = c;
                end
                return;
            end else begin
                idx = (idx + 1 >= size) ? 0 : idx + 1;
            end
        end
        if (op == OP_INSERT) push_result(ST_TBL_FULL, 0, 0, '0, 1'b1);
        else push_result(ST_NOT_FOUND, 0, 0, '0, 1'b1);
    endtask

    // sender
    task automatic send_item(t_op op, logic [63:0] key, logic [15:0] handle, output int n_out);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {handle, key};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predict_op(op, key, handle, n_out);
    endtask

    task automatic write_size(int value);
        i_s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_size = value & 11'h7FF;
    endtask

    function automatic t_row mk_row(t_op op, logic [63:0] key, logic [15:0] handle,
                                    logic typed = 0, t_status st = ST_NEW_SLOT,
                                    logic [10:0] ent = 0);
        t_row r;
        r.op = op; r.key = key; r.handle = handle;
        r.typed = typed; r.exp_status = st; r.exp_entries = ent;
        return r;
    endfunction

    initial begin
        t_row        rows [$];
        t_result     r;
        int          n_out;
        int          sizes [8] = '{2, 0, 7, 2047, 64, 1, 1024, 5};
        logic [63:0] pool [10];
        t_op         op;
        logic [63:0] key;
        int          pick;

        for (int i = 0; i < DEPTH; i++) shadow_counts[i] = 0;
        shadow_entries = 0;
        shadow_size = 1024;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk_row(OP_LOOKUP, 64'd0, 16'h0, 1, ST_NOT_FOUND, 0));
        rows.push_back(mk_row(OP_INSERT, 64'd0, 16'h0000));
        rows.push_back(mk_row(OP_INSERT, '1, 16'hFFFF));
        rows.push_back(mk_row(OP_LOOKUP, '1, 16'h1234));
        rows.push_back(mk_row(OP_NONE, 64'h0123_4567_89AB_CDEF, 16'hAAAA));
        for (int i = 0; i < 9; i++)
            rows.push_back(mk_row(OP_INSERT, 64'h8000_0000_0000_0001, 16'(16'h5A00 + i)));
        rows.push_back(mk_row(OP_LOOKUP, 64'h8000_0000_0000_0001, 16'h0));
        rows.push_back(mk_row(OP_LOOKUP, 64'd0, 16'h0));
        rows.push_back(mk_row(OP_CLEAR, '1, 16'hFFFF, 1, ST_CLEARED, 0));
        rows.push_back(mk_row(OP_LOOKUP, '1, 16'h0, 1, ST_NOT_FOUND, 0));

        foreach (rows[i]) begin
            send_item(rows[i].op, rows[i].key, rows[i].handle, n_out);
            if (rows[i].typed) begin
                repeat (n_out) void'(pending_results.pop_back());
                r.status = rows[i].exp_status; r.slot = 0; r.cnt = 0; r.value = 0;
                r.last = 1'b1; r.entries = rows[i].exp_entries;
                pending_results.push_back(r);
            end
        end

        foreach (sizes[p]) begin
            write_size(sizes[p]);
            foreach (pool[i]) pool[i] = {$urandom, $urandom};
            for (int n = 0; n < 56; n++) begin
                pick = $urandom_range(0, 99);
                op = pick < 55 ? OP_INSERT : pick < 88 ? OP_LOOKUP : pick < 94 ? OP_CLEAR : OP_NONE;
                key = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 9)]
                                                  : {$urandom, $urandom};
                send_item(op, key, 16'($urandom), n_out);
            end
        end

        i_s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver
    initial begin
        int      gap;
        bit      held;
        t_result w;
        held = 0;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 10);
            if (rx_count == 30 && !held) begin
                gap  = HOLD_LEN;
                held = 1;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            rx_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(o_m_tdata), 64'd0);
            end else begin
                w = pending_results.pop_front();
                if (o_m_tdata[2:0] != w.status)
                    report_mismatch("status", 64'(o_m_tdata[2:0]), 64'(w.status));
                if (o_m_tdata[12:3] != w.slot)
                    report_mismatch("slot", 64'(o_m_tdata[12:3]), 64'(w.slot));
                if (o_m_tdata[16:13] != w.cnt)
                    report_mismatch("value_count", 64'(o_m_tdata[16:13]), 64'(w.cnt));
                if (o_m_tdata[32:17] != w.value)
                    report_mismatch("value_out", 64'(o_m_tdata[32:17]), 64'(w.value));
                if (o_m_tdata[43:33] != w.entries)
                    report_mismatch("entry_count", 64'(o_m_tdata[43:33]), 64'(w.entries));
                if (o_m_tdata[47:44] != 4'd0)
                    report_mismatch("pad", 64'(o_m_tdata[47:44]), 64'd0);
                if (o_m_tlast != w.last)
                    report_mismatch("last", 64'(o_m_tlast), 64'(w.last));
            end
        end
    end

    // watchdog on cycles without any transfer or config write
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
